@@ src/uart3x_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the oversampled UART transceiver.
// Depends on nothing; used by oversampled_uart_transceiver.
package uart3x_pkg;

    // Receive store geometry
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Frame timing in oversampling ticks
    localparam logic [1:0] BIT_TICKS   = 2'd3;
    localparam logic [2:0] RX_BIT_TICKS = 3'd3;
    localparam logic [2:0] START_TICKS = 3'd4;

    // Special byte values
    localparam logic [7:0] DROP_BYTE = 8'hC2;
    localparam logic [7:0] SKIP_BYTE = 8'h0A;

    // Number of data bits packed into a received byte
    localparam logic [3:0] DATA_BITS   = 4'd8;
    localparam logic [3:0] BIT_POS_MAX = 4'd15;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RX_SAMPLES = 1'b0;
    localparam logic CFG_TX_BITS    = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RD_REQ = 3'b010,
        ST_RD_CHK = 3'b100
    } t_state;

endpackage

@@ src/oversampled_uart_transceiver.sv @@
`timescale 1ns / 1ps
// Oversampled UART transceiver: transmitter, receiver and receive byte store.
// Depends on uart3x_pkg.
//
// Usage
//   Requests enter on the slave stream: tuser selects a tick, a send or a read,
//   tdata carries the sampled RX line level and the byte to send. Every request
//   beat produces exactly one result beat on the master stream carrying the TX
//   line level, the busy flag, the send-accepted flag and the read result.
//   Ticks must be issued at three times the baud rate.
// Throughput
//   Ticks, sends and reads of an empty store have their result registered at the edge
//   that takes the request, one request per cycle while the result is not stalled
//   and no read scan runs. A read scans the store through its single registered read
//   port, with a request state and a check state per entry visited.
// Reset
//   i_rst_n is synchronous and active low. The TX line resets low, both
//   directions go idle and the store is emptied by clearing its write index;
//   the store memory itself is not cleared.
// Back-pressure
//   While the result register is full and m_tready is low, no new request is
//   taken; nothing is lost. Configuration writes are taken at any time.
module oversampled_uart_transceiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] rx_pin, [8:1] tx_byte, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] tx_pin, [1] tx_busy, [2] tx_accepted, [3] rd_valid, [11:4] rd_byte, [15:12] zero
    output logic [15:0] m_tdata,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);

    localparam int AW = uart3x_pkg::STORE_AW;

    // Configuration registers
    logic [3:0] r_rx_samples;
    logic [3:0] r_tx_bits;

    // Transmitter state
    logic [9:0] r_tx_shift,     n_tx_shift;
    logic [1:0] r_tx_timer,     n_tx_timer;
    logic [3:0] r_tx_bits_left, n_tx_bits_left;
    logic       r_tx_active,    n_tx_active;
    logic       r_tx_line,      n_tx_line;

    // Receiver state
    logic       r_rx_active,    n_rx_active;
    logic       r_rx_wait_stop, n_rx_wait_stop;
    logic [2:0] r_rx_timer,     n_rx_timer;
    logic [3:0] r_rx_bits_left, n_rx_bits_left;
    logic [3:0] r_rx_bit_pos,   n_rx_bit_pos;
    logic [7:0] r_rx_shift,     n_rx_shift;
    logic [AW-1:0] r_wr_idx,    n_wr_idx;

    // Read sequencer
    uart3x_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_scan_idx,  n_scan_idx;

    // Result register
    logic        r_m_valid, n_m_valid;
    logic [11:0] r_m_data,  n_m_data;

    // Store memory
    logic [7:0]    r_store [uart3x_pkg::STORE_DEPTH];
    logic [7:0]    r_mem_q;
    logic          w_mem_we;
    logic [7:0]    w_mem_wdata;
    logic          w_mem_re;

    // Handshake decode
    logic       w_take;
    logic       w_out_free;
    logic       w_out_load;
    logic [1:0] w_req;
    logic       w_pin;
    logic [7:0] w_byte;
    logic       w_hit;
    logic       w_last;

    assign w_req      = s_tuser;
    assign w_pin      = s_tdata[0];
    assign w_byte     = s_tdata[8:1];
    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = (r_state == uart3x_pkg::ST_IDLE) && w_out_free;
    assign w_take     = s_tvalid && s_tready;
    assign w_hit      = (r_mem_q != uart3x_pkg::SKIP_BYTE) && (r_mem_q != uart3x_pkg::DROP_BYTE);
    assign w_last     = (r_scan_idx == r_wr_idx - AW'(1));

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'd0, r_m_data};

    // Next-state logic for one request and for the read scan
    always_comb begin
        n_tx_shift     = r_tx_shift;
        n_tx_timer     = r_tx_timer;
        n_tx_bits_left = r_tx_bits_left;
        n_tx_active    = r_tx_active;
        n_tx_line      = r_tx_line;
        n_rx_active    = r_rx_active;
        n_rx_wait_stop = r_rx_wait_stop;
        n_rx_timer     = r_rx_timer;
        n_rx_bits_left = r_rx_bits_left;
        n_rx_bit_pos   = r_rx_bit_pos;
        n_rx_shift     = r_rx_shift;
        n_wr_idx       = r_wr_idx;
        n_state        = r_state;
        n_scan_idx     = r_scan_idx;
        n_m_valid      = r_m_valid && !m_tready;
        n_m_data       = r_m_data;
        w_mem_we       = 1'b0;
        w_mem_wdata    = r_rx_shift;
        w_mem_re       = 1'b0;
        w_out_load     = 1'b0;

        unique case (r_state)
            uart3x_pkg::ST_IDLE: begin
                if (w_take) begin
                    w_out_load = 1'b1;
                    n_m_data   = {8'd0, 1'b0, 1'b0, r_tx_active, r_tx_line};
                    unique case (w_req)
                        uart3x_pkg::REQ_TICK: begin
                            // Transmitter: one bit every three ticks
                            if (r_tx_active) begin
                                if (r_tx_timer > 2'd1) begin
                                    n_tx_timer = r_tx_timer - 2'd1;
                                end else begin
                                    n_tx_line  = r_tx_shift[0];
                                    n_tx_shift = {1'b0, r_tx_shift[9:1]};
                                    n_tx_timer = uart3x_pkg::BIT_TICKS;
                                    if (r_tx_bits_left <= 4'd1) begin
                                        n_tx_bits_left = 4'd0;
                                        n_tx_active    = 1'b0;
                                    end else begin
                                        n_tx_bits_left = r_tx_bits_left - 4'd1;
                                    end
                                end
                            end
                            // Receiver: start detect, sampling, stop wait
                            if (r_rx_wait_stop) begin
                                if (r_rx_timer > 3'd1) begin
                                    n_rx_timer = r_rx_timer - 3'd1;
                                end else begin
                                    n_rx_timer     = 3'd0;
                                    n_rx_wait_stop = 1'b0;
                                    n_rx_active    = 1'b0;
                                    if (r_rx_shift != uart3x_pkg::DROP_BYTE) begin
                                        w_mem_we = 1'b1;
                                        if (r_wr_idx == AW'(uart3x_pkg::STORE_DEPTH - 1))
                                            n_wr_idx = '0;
                                        else
                                            n_wr_idx = r_wr_idx + AW'(1);
                                    end
                                end
                            end else if (!r_rx_active) begin
                                if (!w_pin) begin
                                    n_rx_active    = 1'b1;
                                    n_rx_shift     = 8'd0;
                                    n_rx_timer     = uart3x_pkg::START_TICKS;
                                    n_rx_bits_left = r_rx_samples;
                                    n_rx_bit_pos   = 4'd0;
                                end
                            end else begin
                                if (r_rx_timer > 3'd1) begin
                                    n_rx_timer = r_rx_timer - 3'd1;
                                end else begin
                                    n_rx_timer = uart3x_pkg::RX_BIT_TICKS;
                                    if (w_pin && (r_rx_bit_pos < uart3x_pkg::DATA_BITS))
                                        n_rx_shift[r_rx_bit_pos[2:0]] = 1'b1;
                                    if (r_rx_bit_pos < uart3x_pkg::BIT_POS_MAX)
                                        n_rx_bit_pos = r_rx_bit_pos + 4'd1;
                                    if (r_rx_bits_left <= 4'd1) begin
                                        n_rx_bits_left = 4'd0;
                                        n_rx_wait_stop = 1'b1;
                                    end else begin
                                        n_rx_bits_left = r_rx_bits_left - 4'd1;
                                    end
                                end
                            end
                            n_m_data = {8'd0, 1'b0, 1'b0, n_tx_active, n_tx_line};
                        end
                        uart3x_pkg::REQ_SEND: begin
                            if (!r_tx_active) begin
                                n_tx_shift     = {1'b1, w_byte, 1'b0};
                                n_tx_timer     = uart3x_pkg::BIT_TICKS;
                                n_tx_bits_left = r_tx_bits;
                                n_tx_active    = 1'b1;
                                n_m_data       = {8'd0, 1'b0, 1'b1, 1'b1, r_tx_line};
                            end
                        end
                        uart3x_pkg::REQ_READ: begin
                            // Empty store answers at once, else start the scan
                            if (r_wr_idx != '0) begin
                                w_out_load = 1'b0;
                                n_scan_idx = '0;
                                n_state    = uart3x_pkg::ST_RD_REQ;
                            end
                        end
                        default: begin
                            // Unused request kind: report line and busy only
                        end
                    endcase
                    n_m_valid = w_out_load;
                end
            end
            uart3x_pkg::ST_RD_REQ: begin
                w_mem_re = 1'b1;
                n_state  = uart3x_pkg::ST_RD_CHK;
            end
            uart3x_pkg::ST_RD_CHK: begin
                if (w_hit || w_last) begin
                    w_out_load = 1'b1;
                    n_m_valid  = 1'b1;
                    n_m_data   = {(w_hit ? r_mem_q : 8'd0), w_hit, 1'b0, r_tx_active, r_tx_line};
                    n_wr_idx   = '0;
                    n_state    = uart3x_pkg::ST_IDLE;
                end else begin
                    n_scan_idx = r_scan_idx + AW'(1);
                    n_state    = uart3x_pkg::ST_RD_REQ;
                end
            end
            default: begin
                n_state = uart3x_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_samples   <= 4'd10;
            r_tx_bits      <= 4'd10;
            r_tx_shift     <= 10'd0;
            r_tx_timer     <= 2'd0;
            r_tx_bits_left <= 4'd0;
            r_tx_active    <= 1'b0;
            r_tx_line      <= 1'b0;
            r_rx_active    <= 1'b0;
            r_rx_wait_stop <= 1'b0;
            r_rx_timer     <= 3'd0;
            r_rx_bits_left <= 4'd0;
            r_rx_bit_pos   <= 4'd0;
            r_rx_shift     <= 8'd0;
            r_wr_idx       <= '0;
            r_state        <= uart3x_pkg::ST_IDLE;
            r_scan_idx     <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    uart3x_pkg::CFG_RX_SAMPLES: r_rx_samples <= i_cfg_data;
                    uart3x_pkg::CFG_TX_BITS:    r_tx_bits    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_tx_shift     <= n_tx_shift;
            r_tx_timer     <= n_tx_timer;
            r_tx_bits_left <= n_tx_bits_left;
            r_tx_active    <= n_tx_active;
            r_tx_line      <= n_tx_line;
            r_rx_active    <= n_rx_active;
            r_rx_wait_stop <= n_rx_wait_stop;
            r_rx_timer     <= n_rx_timer;
            r_rx_bits_left <= n_rx_bits_left;
            r_rx_bit_pos   <= n_rx_bit_pos;
            r_rx_shift     <= n_rx_shift;
            r_wr_idx       <= n_wr_idx;
            r_state        <= n_state;
            r_scan_idx     <= n_scan_idx;
            r_m_valid      <= n_m_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    // Receive store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[r_wr_idx] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_mem_q <= r_store[r_scan_idx];
        end
    end

    // A read scan never overlaps a store write
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != uart3x_pkg::ST_IDLE) |-> !w_mem_we)
        else $error("store written during a read scan");

    // The result register is only loaded when it is free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("result overwritten before it was taken");

    // A finished scan leaves the store empty
    a_scan_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == uart3x_pkg::ST_RD_CHK) && (w_hit || w_last)) |=> (r_wr_idx == '0))
        else $error("store not emptied after a read");

    // The stop wait only happens inside an active reception
    a_stop_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_wait_stop |-> r_rx_active)
        else $error("stop wait outside a frame");

    // An idle transmitter has no bits left to send
    a_tx_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tx_active |-> (r_tx_bits_left == 4'd0))
        else $error("idle transmitter with bits pending");

endmodule
